FILE: rtl/multicast_source_filter_table_assert.svh
// Assertion macro used by the checker file.
// Needs a clock and a reset in scope at the place of use.
`ifndef MULTICAST_SOURCE_FILTER_TABLE_ASSERT_SVH
`define MULTICAST_SOURCE_FILTER_TABLE_ASSERT_SVH
// Check a property on the rising clock edge, off while reset is asserted.
`define MSFT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`endif

FILE: rtl/msft_pkg.sv
// Package of the multicast source filter table: operation and status codes.
// No dependencies.
package msft_pkg;
  localparam int unsigned GroupSlotsDef = 8;
  localparam int unsigned SourcesPerGroupDef = 8;
  localparam int unsigned AddrW = 32;
  localparam int unsigned OpW = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned SlotOutW = 3;

  localparam logic [OpW-1:0] OP_QUERY  = 3'd0;
  localparam logic [OpW-1:0] OP_CREATE = 3'd1;
  localparam logic [OpW-1:0] OP_SETMD  = 3'd2;
  localparam logic [OpW-1:0] OP_ADD    = 3'd3;
  localparam logic [OpW-1:0] OP_REMOVE = 3'd4;
  localparam logic [OpW-1:0] OP_DELETE = 3'd5;

  localparam logic [StatusW-1:0] ST_OK           = 2'd0;
  localparam logic [StatusW-1:0] ST_NOT_FOUND    = 2'd1;
  localparam logic [StatusW-1:0] ST_NO_RESOURCES = 2'd2;
  localparam logic [StatusW-1:0] ST_ZERO_ADDR    = 2'd3;

  // Command broadcast from the sequencer to every group cell.
  typedef struct packed {
    logic       search;   // never set by the sequencer and not read by the cells
    logic       create;   // claim the selected slot
    logic       setmd;    // set mode, clear list
    logic       clear;    // free the selected slot
    logic       shift;    // advance the source walk one position
    logic       append;   // write source at the list end
    logic       fmode;
  } msft_cmd_t;
endpackage

FILE: rtl/msft_cell.sv
// One group slot: address, mode, source list as a shift ring.
// Uses msft_pkg. The ring rotates one entry per walk cycle.
module msft_cell #(
  parameter int unsigned SourcesPerGroup = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  msft_pkg::msft_cmd_t         cmd_i,
  input  logic                        sel_i,
  input  logic [msft_pkg::AddrW-1:0]  grp_i,
  input  logic [msft_pkg::AddrW-1:0]  src_i,
  input  logic                        drop_i,
  output logic                        match_o,
  output logic                        free_o,
  output logic                        excl_o,
  output logic [$clog2(SourcesPerGroup+1)-1:0] cnt_o,
  output logic [msft_pkg::AddrW-1:0]  head_o
);
  import msft_pkg::*;
  localparam int unsigned CntW = $clog2(SourcesPerGroup + 1);
  localparam int unsigned Depth = SourcesPerGroup;
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [AddrW-1:0] addr_q;
  logic             excl_q;
  logic [CntW-1:0]  cnt_q;
  logic [AddrW-1:0] ring_q [Depth];
  logic [CntW-1:0]  tail_idx;

  assign match_o  = (addr_q == grp_i) && (addr_q != '0);
  assign free_o   = (addr_q == '0);
  assign excl_o   = excl_q;
  assign cnt_o    = cnt_q;
  assign head_o   = ring_q[0];
  assign tail_idx = cnt_q - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      excl_q <= 1'b0;
      cnt_q  <= '0;
    end else if (sel_i) begin
      if (cmd_i.create) begin
        addr_q <= grp_i;
        excl_q <= 1'b0;
        cnt_q  <= '0;
      end else if (cmd_i.setmd) begin
        excl_q <= cmd_i.fmode;
        cnt_q  <= '0;
      end else if (cmd_i.clear) begin
        addr_q <= '0;
        excl_q <= 1'b0;
        cnt_q  <= '0;
      end else if (cmd_i.append) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (cmd_i.shift && drop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Walk: rotate the first cnt entries; on drop, skip the head (compacts list).
  // Append writes at position cnt.
  always_ff @(posedge clk_i) begin
    if (sel_i && cmd_i.append) begin
      ring_q[cnt_q[IdxW-1:0]] <= src_i;
    end else if (sel_i && cmd_i.shift) begin
      for (int j = 0; j < Depth - 1; j++) begin
        ring_q[j] <= ring_q[j+1];
      end
      if (!drop_i) begin
        ring_q[tail_idx[IdxW-1:0]] <= ring_q[0];
      end
    end
  end
endmodule

FILE: rtl/multicast_source_filter_table.sv
// Multicast source filter table: one command channel in, one result channel out.
// An input beat carries mode_i, group_address_i, source_address_i and
// filter_mode_i; the result beat carries accept_o, status_o, slot_index_o.
// Valid/stall handshake on both sides; a beat moves when valid is high and
// stall is low.
// Each group slot is a cell; its source list is a ring that rotates once
// per cycle while a query, add or remove walks it.
// Query, add and remove on a matching group walk the list in S_WALK
// before S_APPLY; other valid operations go from S_FIND to S_APPLY.
// One beat is in work at a time; the next is taken the cycle after the
// result moves into the output register.
// Reset clears every slot to free, include mode, empty list, and empties the
// result register. The source entries themselves are not cleared; only the
// first count entries are ever read.
// A stalled result holds in place; the item behind it finishes its work and
// then waits, with the input stalled, until the output register is taken.
module multicast_source_filter_table #(
  parameter int unsigned GROUP_SLOTS = msft_pkg::GroupSlotsDef,
  parameter int unsigned SOURCES_PER_GROUP = msft_pkg::SourcesPerGroupDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [msft_pkg::OpW-1:0]       mode_i,
  input  logic [msft_pkg::AddrW-1:0]     group_address_i,
  input  logic [msft_pkg::AddrW-1:0]     source_address_i,
  input  logic                           filter_mode_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           accept_o,
  output logic [msft_pkg::StatusW-1:0]   status_o,
  output logic [msft_pkg::SlotOutW-1:0]  slot_index_o
);
  import msft_pkg::*;
  localparam int unsigned SlotW = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SOURCES_PER_GROUP + 1);
  localparam int unsigned WalkW = $clog2(SOURCES_PER_GROUP + 1);

  typedef enum logic [2:0] {S_IDLE, S_FIND, S_WALK, S_APPLY, S_DONE} state_e;

  state_e              state_q;
  logic [OpW-1:0]      op_q;
  logic [AddrW-1:0]    grp_q, src_q;
  logic                fm_q;
  logic [SlotW-1:0]    slot_q;
  logic                hit_q, found_q;
  logic [WalkW-1:0]    walk_q;
  logic [CntW-1:0]     len_q;
  logic                out_valid_q, accept_q;
  logic [StatusW-1:0]  status_q;
  logic [SlotOutW-1:0] slot_out_q;
  logic                out_accept_q;
  logic [StatusW-1:0]  out_status_q;
  logic [SlotOutW-1:0] out_slot_q;
  logic                out_load;

  msft_cmd_t          cmd;
  logic [GROUP_SLOTS-1:0] match, free, excl, sel;
  logic [CntW-1:0]    cnt [GROUP_SLOTS];
  logic [AddrW-1:0]   head [GROUP_SLOTS];
  logic               any_match, any_free;
  logic [SlotW-1:0]   match_idx, free_idx;
  logic               drop;

  for (genvar g = 0; g < GROUP_SLOTS; g++) begin : g_cell
    assign sel[g] = (slot_q == SlotW'(g));
    msft_cell #(.SourcesPerGroup(SOURCES_PER_GROUP)) u_cell (
      .clk_i, .rst_ni, .cmd_i(cmd), .sel_i(sel[g]), .grp_i(grp_q), .src_i(src_q),
      .drop_i(drop), .match_o(match[g]), .free_o(free[g]), .excl_o(excl[g]),
      .cnt_o(cnt[g]), .head_o(head[g])
    );
  end

  always_comb begin
    any_match = 1'b0; match_idx = '0;
    any_free  = 1'b0; free_idx  = '0;
    for (int g = GROUP_SLOTS - 1; g >= 0; g--) begin
      if (match[g]) begin any_match = 1'b1; match_idx = SlotW'(g); end
      if (free[g])  begin any_free  = 1'b1; free_idx  = SlotW'(g); end
    end
  end

  // Head matches the source during the walk of the selected slot.
  logic head_eq;
  assign head_eq = (walk_q < WalkW'(len_q)) && (head[slot_q] == src_q);
  assign drop = (op_q == OP_REMOVE) && head_eq && !found_q;

  always_comb begin
    cmd = '0;
    cmd.fmode = fm_q;
    if (state_q == S_WALK && walk_q < WalkW'(len_q)) cmd.shift = 1'b1;
    if (state_q == S_APPLY && hit_q) begin
      unique case (op_q)
        OP_CREATE: cmd.create = !found_q;
        OP_SETMD:  cmd.setmd = 1'b1;
        OP_DELETE: cmd.clear = 1'b1;
        OP_ADD:    cmd.append = !found_q && (len_q < CntW'(SOURCES_PER_GROUP));
        default:   ;
      endcase
    end
  end

  // Move the finished beat into the output register once it is free.
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign accept_o     = out_accept_q;
  assign status_o     = out_status_q;
  assign slot_index_o = out_slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      walk_q      <= '0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_FIND;
        S_FIND: begin
          walk_q <= '0;
          if (op_q > OP_DELETE || grp_q == '0) begin
            state_q <= S_DONE;
          end else if (op_q == OP_QUERY || op_q == OP_ADD || op_q == OP_REMOVE) begin
            state_q <= any_match ? S_WALK : S_APPLY;
          end else begin
            state_q <= S_APPLY;
          end
        end
        S_WALK: begin
          walk_q <= walk_q + 1'b1;
          if (walk_q == WalkW'(SOURCES_PER_GROUP - 1)) state_q <= S_APPLY;
        end
        S_APPLY: state_q <= S_DONE;
        S_DONE: if (out_load) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        op_q <= mode_i; grp_q <= group_address_i;
        src_q <= source_address_i; fm_q <= filter_mode_i;
      end
      S_FIND: begin
        found_q  <= 1'b0;
        accept_q <= 1'b0;
        status_q <= ST_OK;
        slot_out_q <= '0;
        if (op_q > OP_DELETE) begin
          hit_q <= 1'b0;
        end else if (grp_q == '0) begin
          hit_q <= 1'b0; status_q <= ST_ZERO_ADDR;
        end else if (op_q == OP_CREATE) begin
          hit_q   <= any_match || any_free;
          found_q <= any_match;
          slot_q  <= any_match ? match_idx : free_idx;
          if (!any_match && !any_free) status_q <= ST_NO_RESOURCES;
        end else begin
          hit_q  <= any_match;
          slot_q <= match_idx;
          if (!any_match) status_q <= ST_NOT_FOUND;
        end
        len_q <= cnt[any_match ? match_idx : free_idx];
      end
      S_WALK: if (head_eq) found_q <= 1'b1;
      S_APPLY: begin
        if (hit_q) begin
          slot_out_q <= SlotOutW'(slot_q);
          if (op_q == OP_QUERY) accept_q <= excl[slot_q] ^ found_q;
          if (op_q == OP_ADD && !found_q && len_q >= CntW'(SOURCES_PER_GROUP)) begin
            status_q <= ST_NO_RESOURCES;
            slot_out_q <= '0;
          end
        end
      end
      S_DONE: if (out_load) begin
        out_accept_q <= accept_q;
        out_status_q <= status_q;
        out_slot_q   <= slot_out_q;
      end
      default: ;
    endcase
  end
endmodule

FILE: rtl/msft_checker.sv
// Port-level checks of the multicast source filter table, bound to the top.
// Uses msft_pkg and the assertion macro header.
`include "multicast_source_filter_table_assert.svh"
module msft_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          accept_o,
  input logic [msft_pkg::StatusW-1:0]  status_o,
  input logic [msft_pkg::SlotOutW-1:0] slot_index_o
);
  import msft_pkg::*;
  `MSFT_ASSERT(a_accept_ok, clk_i, rst_ni, out_valid_o && accept_o |-> status_o == ST_OK)
  `MSFT_ASSERT(a_slot_err, clk_i, rst_ni,
    out_valid_o && status_o != ST_OK |-> slot_index_o == '0)
  `MSFT_ASSERT(a_busy, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o)
  `MSFT_ASSERT(a_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
endmodule

bind multicast_source_filter_table msft_checker u_msft_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .accept_o, .status_o, .slot_index_o
);

FILE: test/testbench.sv
// Testbench for multicast_source_filter_table: directed and random command beats,
// results checked against a behavioral model of the group/source filter table.
// Depends on msft_pkg and the multicast_source_filter_table RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import msft_pkg::*;

  localparam int NSLOT = 8;
  localparam int NSRC = 8;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic                accept;
    logic [StatusW-1:0]  status;
    logic [SlotOutW-1:0] slot;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [OpW-1:0] mode_i = '0;
  logic [AddrW-1:0] group_address_i = '0;
  logic [AddrW-1:0] source_address_i = '0;
  logic filter_mode_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic accept_o;
  logic [StatusW-1:0] status_o;
  logic [SlotOutW-1:0] slot_index_o;

  multicast_source_filter_table uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // model state
  logic [AddrW-1:0] grp_addr [NSLOT];
  logic             grp_excl [NSLOT];
  int               src_cnt [NSLOT];
  logic [AddrW-1:0] src_list [NSLOT][NSRC];
  verdict_t pending_verdicts[$];
  int errors = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int hold_cycles = 0;
  int cycles = 0;
  logic [AddrW-1:0] pool [6];

  function automatic int find_grp(logic [AddrW-1:0] a);
    for (int i = 0; i < NSLOT; i++) if (grp_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic int find_src(int s, logic [AddrW-1:0] a);
    for (int j = 0; j < src_cnt[s]; j++) if (src_list[s][j] == a) return j;
    return -1;
  endfunction

  function automatic verdict_t filter_decide(logic [OpW-1:0] op, logic [AddrW-1:0] g,
                                             logic [AddrW-1:0] s, logic fm);
    verdict_t v;
    int slot, pos;
    v = '0;
    if (op > OP_DELETE) return v;
    if (g == '0) begin
      v.status = ST_ZERO_ADDR;
      return v;
    end
    slot = find_grp(g);
    if (op == OP_CREATE) begin
      if (slot < 0) begin
        for (int i = 0; i < NSLOT; i++) if (grp_addr[i] == '0) begin
          slot = i;
          grp_addr[i] = g;
          grp_excl[i] = 1'b0;
          src_cnt[i] = 0;
          break;
        end
      end
      if (slot < 0) v.status = ST_NO_RESOURCES;
    end else if (slot < 0) begin
      v.status = ST_NOT_FOUND;
    end else begin
      case (op)
        OP_QUERY: begin
          pos = find_src(slot, s);
          v.accept = grp_excl[slot] ? (pos < 0) : (pos >= 0);
        end
        OP_SETMD: begin
          grp_excl[slot] = fm;
          src_cnt[slot] = 0;
        end
        OP_ADD: if (find_src(slot, s) < 0) begin
          if (src_cnt[slot] < NSRC) begin
            src_list[slot][src_cnt[slot]] = s;
            src_cnt[slot]++;
          end else v.status = ST_NO_RESOURCES;
        end
        OP_REMOVE: begin
          pos = find_src(slot, s);
          if (pos >= 0) begin
            for (int j = pos + 1; j < src_cnt[slot]; j++)
              src_list[slot][j-1] = src_list[slot][j];
            src_cnt[slot]--;
          end
        end
        default: begin
          grp_addr[slot] = '0;
          grp_excl[slot] = 1'b0;
          src_cnt[slot] = 0;
        end
      endcase
    end
    if (v.status == ST_OK && slot >= 0) v.slot = slot[SlotOutW-1:0];
    return v;
  endfunction

  // Valid stays high into the next beat unless the sender idles.
  task automatic send_beat(logic [OpW-1:0] op, logic [AddrW-1:0] g,
                           logic [AddrW-1:0] s, logic fm);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= op;
    group_address_i <= g;
    source_address_i <= s;
    filter_mode_i <= fm;
    do @(posedge clk_i); while (in_stall_o);
    pending_verdicts.push_back(filter_decide(op, g, s, fm));
  endtask

  // receiver stall
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else
      out_stall_i <= recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct;
  end

  // result check
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat");
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (exp_v.accept !== accept_o || exp_v.status !== status_o ||
            exp_v.slot !== slot_index_o) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected accept %0d status %0d slot %0d, got %0d %0d %0d",
                     exp_v.accept, exp_v.status, exp_v.slot, accept_o, status_o,
                     slot_index_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic logic [AddrW-1:0] pick_addr();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return $urandom();
      default: return pool[$urandom_range(5)];
    endcase
  endfunction

  task automatic test_directed();
    send_beat(OP_QUERY, '0, '0, 1'b0);
    send_beat(OP_QUERY, 32'hE000_0001, '1, 1'b0);
    send_beat(OP_CREATE, '1, '0, 1'b0);
    send_beat(OP_CREATE, '1, '0, 1'b0);
    send_beat(OP_QUERY, '1, '0, 1'b0);
    for (int i = 0; i < NSRC; i++) send_beat(OP_ADD, '1, i, 1'b1);
    send_beat(OP_ADD, '1, 3, 1'b0);
    send_beat(OP_ADD, '1, '1, 1'b0);
    send_beat(OP_QUERY, '1, 3, 1'b0);
    send_beat(OP_REMOVE, '1, 3, 1'b0);
    send_beat(OP_REMOVE, '1, 99, 1'b0);
    send_beat(OP_SETMD, '1, '0, 1'b1);
    send_beat(OP_QUERY, '1, 5, 1'b0);
    send_beat(OP_SETMD, 32'h1234, '0, 1'b1);
    send_beat(3'd6, '1, '1, 1'b1);
    send_beat(3'd7, '0, '0, 1'b0);
    send_beat(OP_DELETE, '1, '0, 1'b0);
    send_beat(OP_DELETE, '1, '0, 1'b0);
  endtask

  task automatic test_table_full();
    for (int i = 1; i <= NSLOT + 1; i++) send_beat(OP_CREATE, 32'hE100_0000 + i, '0, 1'b0);
    for (int i = 1; i <= NSLOT; i++) send_beat(OP_DELETE, 32'hE100_0000 + i, '0, 1'b0);
  endtask

  task automatic test_random(int n);
    logic [2:0] op;
    for (int k = 0; k < n; k++) begin
      op = $urandom_range(19) == 0 ? 3'($urandom_range(7)) :
           3'(($urandom_range(9) < 4) ? OP_QUERY : $urandom_range(1, 5));
      if ($urandom_range(9) == 0 && op == OP_DELETE) op = OP_ADD;
      send_beat(op, pick_addr(), $urandom_range(3) == 0 ? $urandom() : 32'($urandom_range(9)),
                1'($urandom()));
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    test_random(20);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    pool[0] = '1;
    for (int i = 1; i < 6; i++) pool[i] = 32'hE000_0000 | $urandom_range(1, 7);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    send_idle_pct = 37;
    recv_idle_pct = 77;
    test_random(550);
    send_idle_pct = 77;
    recv_idle_pct = 37;
    test_random(550);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(600);
    drain();
    if (errors == 0 && pending_verdicts.size() == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end
endmodule
